[design/tbp_pkg.sv]
package tbp_pkg;

    localparam int unsigned PC_W      = 32;
    localparam int unsigned OPC_W     = 7;
    localparam int unsigned COND_W    = 3;
    localparam int unsigned OFF_W     = 13;
    localparam int unsigned TAG_SHIFT = 10;
    localparam int unsigned TAG_W     = PC_W - TAG_SHIFT;
    localparam int unsigned CTR_W     = 2;

    localparam logic [OPC_W-1:0] BRANCH_OPCODE = 7'b1100011;
    localparam logic [PC_W-1:0]  PC_STEP       = 32'd4;

    localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;
    localparam logic [CTR_W-1:0] CTR_MIN = 2'd0;

    typedef enum logic [COND_W-1:0] {
        COND_EQ  = 3'd0,
        COND_NE  = 3'd1,
        COND_LT  = 3'd2,
        COND_GE  = 3'd3,
        COND_LTU = 3'd4,
        COND_GEU = 3'd5
    } t_cond;

    typedef enum logic {
        ACT_FETCH   = 1'b0,
        ACT_RESOLVE = 1'b1
    } t_action;

    // one table entry as held in the memory
    typedef struct packed {
        logic             valid;
        logic [CTR_W-1:0] ctr;
        logic [TAG_W-1:0] tag;
        logic [PC_W-1:0]  target;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic                    action;
        logic [PC_W-1:0]         pc;
        logic [OPC_W-1:0]        opcode_bits;
        logic [COND_W-1:0]       condition;
        logic [PC_W-1:0]         operand_a;
        logic [PC_W-1:0]         operand_b;
        logic signed [OFF_W-1:0] offset;
        logic                    carried_taken;
        logic [PC_W-1:0]         carried_target;
    } t_req;

    typedef struct packed {
        logic            predict_taken;
        logic [PC_W-1:0] predict_target;
        logic [PC_W-1:0] next_fetch_pc;
        logic            branch_taken;
        logic            mispredict;
        logic [PC_W-1:0] redir_pc;
    } t_rsp;

endpackage

[design/tbp_if.sv]
interface tbp_req_if;
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic [tbp_pkg::PC_W-1:0]         pc;
    logic [tbp_pkg::OPC_W-1:0]        opcode_bits;
    logic [tbp_pkg::COND_W-1:0]       condition;
    logic [tbp_pkg::PC_W-1:0]         operand_a;
    logic [tbp_pkg::PC_W-1:0]         operand_b;
    logic signed [tbp_pkg::OFF_W-1:0] offset;
    logic                             carried_taken;
    logic [tbp_pkg::PC_W-1:0]         carried_target;

    modport source (
        output valid, action, pc, opcode_bits, condition, operand_a, operand_b,
               offset, carried_taken, carried_target,
        input  ready
    );
    modport sink (
        input  valid, action, pc, opcode_bits, condition, operand_a, operand_b,
               offset, carried_taken, carried_target,
        output ready
    );
endinterface

interface tbp_rsp_if;
    logic                     valid;
    logic                     ready;
    logic                     predict_taken;
    logic [tbp_pkg::PC_W-1:0] predict_target;
    logic [tbp_pkg::PC_W-1:0] next_fetch_pc;
    logic                     branch_taken;
    logic                     mispredict;
    logic [tbp_pkg::PC_W-1:0] redir_pc;

    modport source (
        output valid, predict_taken, predict_target, next_fetch_pc, branch_taken,
               mispredict, redir_pc,
        input  ready
    );
    modport sink (
        input  valid, predict_taken, predict_target, next_fetch_pc, branch_taken,
               mispredict, redir_pc,
        output ready
    );
endinterface

[design/tbp_ram.sv]
module tbp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/tbp_exec.sv]
module tbp_exec (
    input  tbp_pkg::t_req   i_req,
    input  tbp_pkg::t_entry i_entry,
    output tbp_pkg::t_rsp   o_rsp,
    output tbp_pkg::t_entry o_entry
);

    logic                     hit;
    logic                     pred_taken;
    logic [tbp_pkg::PC_W-1:0] seq_pc;
    logic [tbp_pkg::PC_W-1:0] br_target;
    logic                     cond_true;
    logic                     miss;
    logic [tbp_pkg::CTR_W-1:0] new_ctr;

    assign seq_pc    = i_req.pc + tbp_pkg::PC_STEP;
    assign br_target = i_req.pc + tbp_pkg::PC_W'(i_req.offset);

    assign hit = i_entry.valid
              && (i_entry.tag == i_req.pc[tbp_pkg::PC_W-1:tbp_pkg::TAG_SHIFT])
              && (i_req.opcode_bits == tbp_pkg::BRANCH_OPCODE);
    // counter at weakly taken or above
    assign pred_taken = hit && i_entry.ctr[tbp_pkg::CTR_W-1];

    always_comb begin
        unique case (i_req.condition)
            tbp_pkg::COND_EQ:  cond_true = (i_req.operand_a == i_req.operand_b);
            tbp_pkg::COND_NE:  cond_true = (i_req.operand_a != i_req.operand_b);
            tbp_pkg::COND_LT:  cond_true = ($signed(i_req.operand_a) <
                                            $signed(i_req.operand_b));
            tbp_pkg::COND_GE:  cond_true = ($signed(i_req.operand_a) >=
                                            $signed(i_req.operand_b));
            tbp_pkg::COND_LTU: cond_true = (i_req.operand_a < i_req.operand_b);
            tbp_pkg::COND_GEU: cond_true = (i_req.operand_a >= i_req.operand_b);
            default:           cond_true = 1'b0;
        endcase
    end

    assign miss = i_req.carried_taken ? (!cond_true || (i_req.carried_target != br_target))
                                      : cond_true;

    always_comb begin
        new_ctr = i_entry.ctr;
        if (cond_true) begin
            if (i_entry.ctr != tbp_pkg::CTR_MAX) begin
                new_ctr = i_entry.ctr + 1'b1;
            end
        end else begin
            if (i_entry.ctr != tbp_pkg::CTR_MIN) begin
                new_ctr = i_entry.ctr - 1'b1;
            end
        end
    end

    always_comb begin
        o_rsp = '0;
        if (i_req.action == tbp_pkg::ACT_FETCH) begin
            o_rsp.predict_taken  = pred_taken;
            o_rsp.predict_target = hit ? i_entry.target : '0;
            o_rsp.next_fetch_pc  = pred_taken ? i_entry.target : seq_pc;
        end else begin
            o_rsp.branch_taken = cond_true;
            o_rsp.mispredict   = miss;
            o_rsp.redir_pc     = miss ? (cond_true ? br_target : seq_pc) : '0;
        end
    end

    assign o_entry.valid  = 1'b1;
    assign o_entry.ctr    = new_ctr;
    assign o_entry.tag    = i_req.pc[tbp_pkg::PC_W-1:tbp_pkg::TAG_SHIFT];
    assign o_entry.target = br_target;

endmodule

[design/tagged_btb_two_bit_predictor_top.sv]
// Tagged branch target buffer with 2-bit direction counters.
// i_req carries one word per lookup or branch resolution; action selects
// fetch (lookup only) or resolve (condition check, redirect, table update).
// o_rsp carries exactly one result word per request word, in order.
// Each word is a read-modify-write of one direct-mapped table entry held in
// a single synchronous RAM: the read is issued at acceptance, the data comes
// back in the following cycle, and the result and any write-back happen then.
// A word's result is registered on o_rsp as its execute state ends. No new word
// is taken while one is in execute, since the read-modify-write loop through the
// RAM read allows no overlap between words.
// A new word is taken only when no result waits or the waiting one leaves in
// that cycle; while the receiver stalls on a result, i_req.ready stays low.
// After reset the table is swept to zero, one entry a cycle, through all
// TABLE_ENTRIES entries; i_req.ready is low for the whole sweep.
module tagged_btb_two_bit_predictor_top #(
    parameter int unsigned TABLE_ENTRIES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tbp_req_if.sink   i_req,
    tbp_rsp_if.source o_rsp
);

    localparam int unsigned IW = $clog2(TABLE_ENTRIES);
    localparam logic [IW-1:0] IDX_MASK = IW'(TABLE_ENTRIES - 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [IW-1:0] r_clr_idx, n_clr_idx;
    logic          r_out_valid, n_out_valid;
    tbp_pkg::t_req r_req;
    tbp_pkg::t_rsp r_rsp;

    tbp_pkg::t_req   req_in;
    tbp_pkg::t_rsp   exec_rsp;
    tbp_pkg::t_entry rd_entry;
    tbp_pkg::t_entry upd_entry;
    logic [tbp_pkg::ENTRY_W-1:0] rd_data;
    logic [tbp_pkg::ENTRY_W-1:0] wr_data;
    logic [IW-1:0] rd_idx;
    logic [IW-1:0] wr_idx;
    logic          ram_we;
    logic          in_acc;
    logic          out_acc;

    assign req_in.action         = i_req.action;
    assign req_in.pc             = i_req.pc;
    assign req_in.opcode_bits    = i_req.opcode_bits;
    assign req_in.condition      = i_req.condition;
    assign req_in.operand_a      = i_req.operand_a;
    assign req_in.operand_b      = i_req.operand_b;
    assign req_in.offset         = i_req.offset;
    assign req_in.carried_taken  = i_req.carried_taken;
    assign req_in.carried_target = i_req.carried_target;

    assign out_acc     = r_out_valid && o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign in_acc      = i_req.valid && i_req.ready;

    // index is pc[IW+1:2] masked, so it stays inside an odd-sized table
    assign rd_idx = i_req.pc[IW+1:2] & IDX_MASK;

    always_comb begin
        if (r_state == S_CLEAR) begin
            wr_idx  = r_clr_idx;
            wr_data = '0;
            ram_we  = 1'b1;
        end else begin
            wr_idx  = r_req.pc[IW+1:2] & IDX_MASK;
            wr_data = upd_entry;
            ram_we  = (r_state == S_EXEC) && (r_req.action == tbp_pkg::ACT_RESOLVE);
        end
    end

    tbp_ram #(
        .WIDTH (tbp_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_idx),
        .i_wdata (wr_data),
        .i_raddr (rd_idx),
        .o_rdata (rd_data)
    );

    assign rd_entry = rd_data;

    tbp_exec u_exec (
        .i_req   (r_req),
        .i_entry (rd_entry),
        .o_rsp   (exec_rsp),
        .o_entry (upd_entry)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_out_valid = r_out_valid;
        if (out_acc) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == IDX_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= req_in;
        end
        if (r_state == S_EXEC) begin
            r_rsp <= exec_rsp;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.predict_taken  = r_rsp.predict_taken;
    assign o_rsp.predict_target = r_rsp.predict_target;
    assign o_rsp.next_fetch_pc  = r_rsp.next_fetch_pc;
    assign o_rsp.branch_taken   = r_rsp.branch_taken;
    assign o_rsp.mispredict     = r_rsp.mispredict;
    assign o_rsp.redir_pc       = r_rsp.redir_pc;

    // the result register must be free when the read data comes back
    a_exec_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !r_out_valid)
        else $error("result register busy at execute");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC))
        else $error("accepted word not executed next cycle");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> o_rsp.valid)
        else $error("no result after execute");

    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == S_CLEAR) ||
                    ((r_state == S_EXEC) && (r_req.action == tbp_pkg::ACT_RESOLVE))))
        else $error("table written outside sweep or resolve");

endmodule

[bench/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TABLE_ENTRIES = 256;
    localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int unsigned POOL_SIZE     = 16;
    localparam int unsigned CYCLE_LIMIT   = 100000;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned PRINT_CAP     = 20;

    // condition codes outside the six real branch conditions
    localparam logic [tbp_pkg::COND_W-1:0] COND_RSVD_6 = 3'd6;
    localparam logic [tbp_pkg::COND_W-1:0] COND_RSVD_7 = 3'd7;
    localparam logic [tbp_pkg::OPC_W-1:0]  OPC_ALU     = 7'h33;
    localparam logic [tbp_pkg::OPC_W-1:0]  OPC_ALL1    = 7'h7F;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tbp_req_if req_bus ();
    tbp_rsp_if rsp_bus ();

    tagged_btb_two_bit_predictor_top #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow of the branch table
    logic                          shadow_valid  [TABLE_ENTRIES];
    logic [tbp_pkg::CTR_W-1:0]     shadow_ctr    [TABLE_ENTRIES];
    logic [tbp_pkg::TAG_W-1:0]     shadow_tag    [TABLE_ENTRIES];
    logic [tbp_pkg::PC_W-1:0]      shadow_target [TABLE_ENTRIES];

    tbp_pkg::t_rsp rsp_expected [$];
    tbp_pkg::t_rsp last_lookup;

    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned src_idle_max;
    int unsigned snk_idle_max;
    int unsigned hold_off_cycles;
    int unsigned n_fetch, n_resolve, n_pred_taken, n_mispredict, n_checked;

    logic snk_ready;
    logic hold_active;

    logic [tbp_pkg::PC_W-1:0]  branch_pc   [POOL_SIZE];
    logic [tbp_pkg::OFF_W-1:0] branch_off  [POOL_SIZE];
    logic                      branch_bias [POOL_SIZE];

    assign rsp_bus.ready = snk_ready && !hold_active;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                     rsp_expected.size());
            $display("FAIL tagged_btb_two_bit_predictor_top");
            $finish;
        end
    end

    function automatic logic branch_cond(logic [tbp_pkg::COND_W-1:0] c,
                                         logic [tbp_pkg::PC_W-1:0] a,
                                         logic [tbp_pkg::PC_W-1:0] b);
        case (c)
            tbp_pkg::COND_EQ:  return a == b;
            tbp_pkg::COND_NE:  return a != b;
            tbp_pkg::COND_LT:  return $signed(a) < $signed(b);
            tbp_pkg::COND_GE:  return $signed(a) >= $signed(b);
            tbp_pkg::COND_LTU: return a < b;
            tbp_pkg::COND_GEU: return a >= b;
            default:           return 1'b0;
        endcase
    endfunction

    // lookup or resolve against the shadow table; resolve updates it
    function automatic tbp_pkg::t_rsp btb_predict(tbp_pkg::t_req w);
        tbp_pkg::t_rsp             r;
        logic [IDX_W-1:0]          idx;
        logic [tbp_pkg::TAG_W-1:0] tag;
        logic [tbp_pkg::PC_W-1:0]  tgt;
        logic                      hit;
        logic                      tk;
        r   = '0;
        idx = w.pc[IDX_W+1:2];
        tag = w.pc[tbp_pkg::PC_W-1:tbp_pkg::TAG_SHIFT];
        if (w.action == tbp_pkg::ACT_FETCH) begin
            hit = shadow_valid[idx] && (shadow_tag[idx] == tag) &&
                  (w.opcode_bits == tbp_pkg::BRANCH_OPCODE);
            tk  = hit && (shadow_ctr[idx] >= 2'd2);
            r.predict_taken  = tk;
            r.predict_target = hit ? shadow_target[idx] : '0;
            r.next_fetch_pc  = tk ? shadow_target[idx] : w.pc + tbp_pkg::PC_STEP;
        end else begin
            tgt = w.pc + {{(tbp_pkg::PC_W-tbp_pkg::OFF_W){w.offset[tbp_pkg::OFF_W-1]}},
                          w.offset};
            tk  = branch_cond(w.condition, w.operand_a, w.operand_b);
            r.branch_taken = tk;
            r.mispredict   = w.carried_taken ? (!tk || (w.carried_target != tgt)) : tk;
            if (r.mispredict)
                r.redir_pc = tk ? tgt : w.pc + tbp_pkg::PC_STEP;
            if (tk && shadow_ctr[idx] != tbp_pkg::CTR_MAX)
                shadow_ctr[idx] = shadow_ctr[idx] + 1'b1;
            else if (!tk && shadow_ctr[idx] != tbp_pkg::CTR_MIN)
                shadow_ctr[idx] = shadow_ctr[idx] - 1'b1;
            shadow_valid[idx]  = 1'b1;
            shadow_tag[idx]    = tag;
            shadow_target[idx] = tgt;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [tbp_pkg::PC_W-1:0] exp_v,
                                   logic [tbp_pkg::PC_W-1:0] got_v);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, exp_v, got_v);
    endtask

    task automatic send_word(tbp_pkg::t_req w);
        int unsigned gap;
        gap = $urandom_range(0, src_idle_max);
        repeat (gap) begin
            @(negedge i_clk);
            req_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_bus.valid          <= 1'b1;
        req_bus.action         <= w.action;
        req_bus.pc             <= w.pc;
        req_bus.opcode_bits    <= w.opcode_bits;
        req_bus.condition      <= w.condition;
        req_bus.operand_a      <= w.operand_a;
        req_bus.operand_b      <= w.operand_b;
        req_bus.offset         <= w.offset;
        req_bus.carried_taken  <= w.carried_taken;
        req_bus.carried_target <= w.carried_target;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        last_lookup = btb_predict(w);
        rsp_expected = {rsp_expected, last_lookup};
        if (w.action == tbp_pkg::ACT_FETCH) begin
            n_fetch++;
            if (last_lookup.predict_taken)
                n_pred_taken++;
        end else begin
            n_resolve++;
            if (last_lookup.mispredict)
                n_mispredict++;
        end
    endtask

    // long receiver hold-off on request, counted here
    initial begin
        int unsigned n;
        hold_active = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles != 0) begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
                hold_active <= 1'b1;
                repeat (n) @(negedge i_clk);
                hold_active <= 1'b0;
            end
        end
    end

    // result side: random stalls between words
    initial begin
        tbp_pkg::t_rsp e;
        int unsigned   stall;
        snk_ready = 1'b0;
        forever begin
            stall = $urandom_range(0, snk_idle_max);
            repeat (stall) begin
                @(negedge i_clk);
                snk_ready <= 1'b0;
            end
            @(negedge i_clk);
            snk_ready <= 1'b1;
            do @(posedge i_clk); while (rsp_bus.valid !== 1'b1 || rsp_bus.ready !== 1'b1);
            if (rsp_expected.size() == 0) begin
                report_mismatch("unexpected word", '0, rsp_bus.redir_pc);
            end else begin
                e = rsp_expected.pop_front();
                n_checked++;
                if (rsp_bus.predict_taken !== e.predict_taken)
                    report_mismatch("predict_taken", tbp_pkg::PC_W'(e.predict_taken),
                                    tbp_pkg::PC_W'(rsp_bus.predict_taken));
                if (rsp_bus.predict_target !== e.predict_target)
                    report_mismatch("predict_target", e.predict_target, rsp_bus.predict_target);
                if (rsp_bus.next_fetch_pc !== e.next_fetch_pc)
                    report_mismatch("next_fetch_pc", e.next_fetch_pc, rsp_bus.next_fetch_pc);
                if (rsp_bus.branch_taken !== e.branch_taken)
                    report_mismatch("branch_taken", tbp_pkg::PC_W'(e.branch_taken),
                                    tbp_pkg::PC_W'(rsp_bus.branch_taken));
                if (rsp_bus.mispredict !== e.mispredict)
                    report_mismatch("mispredict", tbp_pkg::PC_W'(e.mispredict),
                                    tbp_pkg::PC_W'(rsp_bus.mispredict));
                if (rsp_bus.redir_pc !== e.redir_pc)
                    report_mismatch("redir_pc", e.redir_pc, rsp_bus.redir_pc);
            end
        end
    end

    function automatic tbp_pkg::t_req random_word();
        tbp_pkg::t_req w;
        w.action         = $urandom_range(0, 1) ? tbp_pkg::ACT_RESOLVE : tbp_pkg::ACT_FETCH;
        w.pc             = $urandom;
        w.opcode_bits    = tbp_pkg::OPC_W'($urandom);
        w.condition      = tbp_pkg::COND_W'($urandom);
        w.operand_a      = $urandom;
        w.operand_b      = $urandom;
        w.offset         = tbp_pkg::OFF_W'($urandom);
        w.carried_taken  = 1'($urandom_range(0, 1));
        w.carried_target = $urandom;
        return w;
    endfunction

    function automatic tbp_pkg::t_req fetch_word(logic [tbp_pkg::PC_W-1:0] pc,
                                                 logic [tbp_pkg::OPC_W-1:0] opc);
        tbp_pkg::t_req w;
        w             = '0;
        w.action      = tbp_pkg::ACT_FETCH;
        w.pc          = pc;
        w.opcode_bits = opc;
        return w;
    endfunction

    function automatic tbp_pkg::t_req resolve_word(logic [tbp_pkg::PC_W-1:0] pc,
                                                   logic [tbp_pkg::COND_W-1:0] c,
                                                   logic [tbp_pkg::PC_W-1:0] a,
                                                   logic [tbp_pkg::PC_W-1:0] b,
                                                   logic [tbp_pkg::OFF_W-1:0] off,
                                                   logic ct,
                                                   logic [tbp_pkg::PC_W-1:0] ctgt);
        tbp_pkg::t_req w;
        w                = '0;
        w.action         = tbp_pkg::ACT_RESOLVE;
        w.pc             = pc;
        w.condition      = c;
        w.operand_a      = a;
        w.operand_b      = b;
        w.offset         = off;
        w.carried_taken  = ct;
        w.carried_target = ctgt;
        return w;
    endfunction

    // a fetch of a known branch followed by its resolve, carrying the fetch prediction
    task automatic run_branch_pair(int unsigned slot);
        tbp_pkg::t_req              f;
        tbp_pkg::t_req              r;
        tbp_pkg::t_rsp              pred;
        logic [tbp_pkg::COND_W-1:0] c;
        logic [tbp_pkg::PC_W-1:0]   a;
        logic [tbp_pkg::PC_W-1:0]   b;
        logic [tbp_pkg::PC_W-1:0]   t;
        logic                       want;
        f        = random_word();
        f.action = tbp_pkg::ACT_FETCH;
        f.pc     = branch_pc[slot];
        if ($urandom_range(0, 9) != 0)
            f.opcode_bits = tbp_pkg::BRANCH_OPCODE;
        send_word(f);
        pred = last_lookup;

        r        = random_word();
        r.action = tbp_pkg::ACT_RESOLVE;
        r.pc     = branch_pc[slot];
        if ($urandom_range(0, 15) == 0)
            c = $urandom_range(0, 1) ? COND_RSVD_7 : COND_RSVD_6;
        else
            c = tbp_pkg::COND_W'($urandom_range(0, 5));
        want = ($urandom_range(0, 3) != 0) ? branch_bias[slot] : !branch_bias[slot];
        a = $urandom;
        b = ($urandom_range(0, 3) == 0) ? a : $urandom;
        if (c == tbp_pkg::COND_EQ || c == tbp_pkg::COND_NE) begin
            b = (want == (c == tbp_pkg::COND_EQ)) ? a : a ^ (32'h1 << $urandom_range(0, 31));
        end else if (c <= tbp_pkg::COND_GEU) begin
            if (a == b)
                b = a ^ 32'h1;
            // with unequal operands, swapping flips every ordered compare
            if (branch_cond(c, a, b) != want) begin
                t = a;
                a = b;
                b = t;
            end
        end
        r.condition = c;
        r.operand_a = a;
        r.operand_b = b;
        if ($urandom_range(0, 7) != 0)
            r.offset = branch_off[slot];
        r.carried_taken  = pred.predict_taken;
        r.carried_target = pred.predict_target;
        if ($urandom_range(0, 9) == 0)
            r.carried_taken = !r.carried_taken;
        if ($urandom_range(0, 9) == 0)
            r.carried_target = $urandom;
        send_word(r);
    endtask

    task automatic test_directed();
        localparam logic [tbp_pkg::PC_W-1:0]  PC_A   = 32'h0000_1040;
        localparam logic [tbp_pkg::PC_W-1:0]  PC_TOP = 32'hFFFF_FFFC;
        localparam logic [tbp_pkg::OFF_W-1:0] OFF_64 = 13'sd64;
        src_idle_max = 2;
        snk_idle_max = 2;
        // cold table, then train one entry up and down through every condition
        send_word(fetch_word(PC_A, tbp_pkg::BRANCH_OPCODE));
        send_word(resolve_word(PC_A, tbp_pkg::COND_EQ, '0, '0, OFF_64, 1'b0, '0));
        send_word(fetch_word(PC_A, tbp_pkg::BRANCH_OPCODE));
        send_word(resolve_word(PC_A, tbp_pkg::COND_NE, '0, 32'hFFFF_FFFF, OFF_64, 1'b0, '0));
        send_word(fetch_word(PC_A, tbp_pkg::BRANCH_OPCODE));
        send_word(fetch_word(PC_A, OPC_ALU));
        send_word(fetch_word(PC_A + 32'h400, tbp_pkg::BRANCH_OPCODE));
        send_word(resolve_word(PC_A, tbp_pkg::COND_LT, 32'h8000_0000, 32'h7FFF_FFFF, OFF_64,
                               1'b1, PC_A + 32'd64));
        send_word(resolve_word(PC_A, tbp_pkg::COND_GE, 32'h7FFF_FFFF, 32'h8000_0000, OFF_64,
                               1'b1, PC_A));
        send_word(resolve_word(PC_A, tbp_pkg::COND_LTU, 32'hFFFF_FFFF, '0, OFF_64, 1'b1,
                               PC_A + 32'd64));
        send_word(resolve_word(PC_A, tbp_pkg::COND_GEU, '0, 32'hFFFF_FFFF, OFF_64, 1'b0, '0));
        send_word(resolve_word(PC_A, COND_RSVD_6, '0, '0, OFF_64, 1'b0, '0));
        send_word(resolve_word(PC_A, COND_RSVD_7, '1, '1, OFF_64, 1'b1, '1));
        send_word(fetch_word(PC_A, tbp_pkg::BRANCH_OPCODE));
        // target and fall-through wrap past the top of the address space
        send_word(resolve_word(PC_TOP, tbp_pkg::COND_EQ, '1, '1, 13'sd8, 1'b0, '0));
        send_word(resolve_word(PC_TOP, tbp_pkg::COND_EQ, '1, '1, 13'sd8, 1'b1, 32'd4));
        send_word(fetch_word(PC_TOP, tbp_pkg::BRANCH_OPCODE));
        send_word(fetch_word(32'hFFFF_FFFF, '0));
        send_word(resolve_word('0, tbp_pkg::COND_LTU, '0, 32'd1, 13'sh1000, 1'b0, '0));
        send_word(resolve_word('0, tbp_pkg::COND_GE, 32'h8000_0000, '0, 13'sd4094, 1'b1,
                               32'hFFFF_F000));
        send_word(fetch_word('0, OPC_ALL1));
        send_word(fetch_word('0, tbp_pkg::BRANCH_OPCODE));
    endtask

    task automatic test_branch_sequences();
        int unsigned phase;
        int unsigned k;
        for (k = 0; k < POOL_SIZE; k++) begin
            // pairs of slots share an index with different tags
            if (k % 2 == 0)
                branch_pc[k] = {22'($urandom), 8'($urandom), 2'b00};
            else
                branch_pc[k] = {22'($urandom), branch_pc[k-1][9:2], 2'b00};
            branch_off[k]  = {12'($urandom), 1'b0};
            branch_bias[k] = 1'($urandom_range(0, 1));
        end
        for (phase = 0; phase < 4; phase++) begin
            src_idle_max = (phase == 0 || phase == 2) ? 14 : 0;
            snk_idle_max = (phase == 0 || phase == 3) ? 14 : 0;
            repeat (35)
                run_branch_pair($urandom_range(0, POOL_SIZE - 1));
        end
    endtask

    task automatic test_back_pressure();
        src_idle_max    = 0;
        snk_idle_max    = 1;
        hold_off_cycles = 60;
        repeat (25)
            run_branch_pair($urandom_range(0, POOL_SIZE - 1));
    endtask

    task automatic test_random_noise();
        tbp_pkg::t_req w;
        src_idle_max = 6;
        snk_idle_max = 6;
        repeat (200) begin
            w = random_word();
            if ($urandom_range(0, 1))
                w.pc = branch_pc[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 4) < 2)
                w.opcode_bits = tbp_pkg::BRANCH_OPCODE;
            send_word(w);
        end
    endtask

    initial begin
        int unsigned k;
        i_rst_n                = 1'b0;
        req_bus.valid          = 1'b0;
        req_bus.action         = tbp_pkg::ACT_FETCH;
        req_bus.pc             = '0;
        req_bus.opcode_bits    = '0;
        req_bus.condition      = tbp_pkg::COND_EQ;
        req_bus.operand_a      = '0;
        req_bus.operand_b      = '0;
        req_bus.offset         = '0;
        req_bus.carried_taken  = 1'b0;
        req_bus.carried_target = '0;
        error_count     = 0;
        cycle_count     = 0;
        hold_off_cycles = 0;
        src_idle_max    = 0;
        snk_idle_max    = 0;
        n_fetch = 0; n_resolve = 0; n_pred_taken = 0; n_mispredict = 0; n_checked = 0;
        for (k = 0; k < TABLE_ENTRIES; k++) begin
            shadow_valid[k]  = 1'b0;
            shadow_ctr[k]    = tbp_pkg::CTR_MIN;
            shadow_tag[k]    = '0;
            shadow_target[k] = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_branch_sequences();
        test_back_pressure();
        test_random_noise();

        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (rsp_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d lookups (%0d predicted taken) and %0d resolves (%0d mispredicts)",
                 n_fetch, n_pred_taken, n_resolve, n_mispredict);
        $display("%0d result words checked, %0d mismatches, %0d cycles", n_checked,
                 error_count, cycle_count);
        if (error_count == 0) begin
            $display("PASS tagged_btb_two_bit_predictor_top");
        end else begin
            $display("FAIL tagged_btb_two_bit_predictor_top");
        end
        $finish;
    end

endmodule

[tagged_btb_two_bit_predictor_top.f]
design/tbp_pkg.sv
design/tbp_if.sv
design/tbp_ram.sv
design/tbp_exec.sv
design/tagged_btb_two_bit_predictor_top.sv
bench/testbench.sv
